>>> src/svm_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants for the space vector PWM modulator.
// No dependencies; every other file imports this package.
package svm_pkg;

  localparam int AngleTableBits = 10;
  localparam logic [15:0] AngleMask =
    16'(((1 << AngleTableBits) - 1) << (16 - AngleTableBits));

  localparam logic [16:0] Sqrt3 = 17'd113512;
  localparam logic [15:0] SinA  = 16'd51472;
  localparam logic [15:0] SinB  = 16'd21024;
  localparam logic [11:0] SinC  = 12'd2320;

  localparam int AbW  = 28;       // alpha / beta
  localparam int MW   = 30;       // sqrt3 * alpha
  localparam int VW   = 31;       // doubled projections
  localparam int XW   = 28;       // active vector magnitudes
  localparam int NW   = 36;       // unscaled vector times
  localparam int QW   = 16;       // scaled vector times
  localparam int SumW = NW + 1;

  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegPeriod = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLimit  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBus    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAfter  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBefore = 3'd4;

  localparam logic [2:0] SecNone = 3'd0;
  localparam logic [2:0] Sec1    = 3'd1;
  localparam logic [2:0] Sec2    = 3'd2;
  localparam logic [2:0] Sec3    = 3'd3;
  localparam logic [2:0] Sec4    = 3'd4;
  localparam logic [2:0] Sec5    = 3'd5;
  localparam logic [2:0] Sec6    = 3'd6;

  typedef struct packed {
    logic [15:0] period;
    logic [15:0] limit;
    logic [14:0] bus;
    logic [15:0] after;
    logic [15:0] prior;
  } cfg_t;

  typedef struct packed {
    logic signed [AbW-1:0] alpha;
    logic signed [AbW-1:0] beta;
  } ab_t;

  typedef struct packed {
    logic [2:0]    sector;
    logic [XW-1:0] x;
    logic [XW-1:0] y;
  } xy_t;

  typedef struct packed {
    logic [2:0]  sector;
    logic [15:0] tx;
    logic [15:0] ty;
    logic        over;
  } vt_t;

  typedef struct packed {
    logic [2:0]  sector;
    logic [15:0] ca;
    logic [15:0] cb;
    logic [15:0] cc;
    logic [15:0] trig;
    logic        over;
  } res_t;

  // sign pattern {V3>0, V2>0, V1>0} to sector
  function automatic logic [2:0] sector_of_n(input logic [2:0] n);
    logic [2:0] s;
    unique case (n)
      3'd3:    s = Sec1;
      3'd1:    s = Sec2;
      3'd5:    s = Sec3;
      3'd4:    s = Sec4;
      3'd6:    s = Sec5;
      3'd2:    s = Sec6;
      default: s = SecNone;
    endcase
    return s;
  endfunction

endpackage

>>> src/svm_park.sv
`timescale 1ns / 1ps
// Sine/cosine polynomial and inverse Park transform, seven register stages.
// Depends on svm_pkg.
module svm_park import svm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  logic [15:0] volt_d_i,
  input  logic [15:0] volt_q_i,
  input  logic [15:0] angle_i,
  output logic        vld_o,
  output ab_t         ab_o
);

  localparam int Lat = 7;

  function automatic logic [15:0] sine_arg(input logic [15:0] p);
    logic [14:0] r;
    r = p[14] ? 15'(15'd16384 - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
    return {r, 1'b0};
  endfunction

  logic [Lat-1:0] vld_q;

  logic [15:0] p_s, p_c;
  logic signed [15:0] d_q [5];
  logic signed [15:0] q_q [5];
  logic [15:0] us_q [4];
  logic [15:0] uc_q [4];
  logic        ns_q [4];
  logic        nc_q [4];
  logic [15:0] u2s_q [2];
  logic [15:0] u2c_q [2];
  logic [15:0] t1s_q, t1c_q, t2s_q, t2c_q;
  logic signed [17:0] sn_q, cs_q;
  logic signed [33:0] dc_q, qs_q, ds_q, qc_q;
  ab_t ab_q;

  logic [31:0] sq_s, sq_c, m3s, m3c, m4s, m4c, m5s, m5c;
  logic [27:0] m2s, m2c;
  logic signed [33:0] dc_d, qs_d, ds_d, qc_d;
  logic [34:0] a_sum, b_sum;

  assign p_s = angle_i & AngleMask;
  assign p_c = p_s + 16'h4000;

  always_comb begin
    sq_s = us_q[0] * us_q[0];
    sq_c = uc_q[0] * uc_q[0];
    m2s  = SinC * u2s_q[0];
    m2c  = SinC * u2c_q[0];
    m3s  = t1s_q * u2s_q[1];
    m3c  = t1c_q * u2c_q[1];
    m4s  = t2s_q * us_q[3];
    m4c  = t2c_q * uc_q[3];
    m5s  = 32'(m4s);
    m5c  = 32'(m4c);
    dc_d = d_q[4] * cs_q;
    qs_d = q_q[4] * sn_q;
    ds_d = d_q[4] * sn_q;
    qc_d = q_q[4] * cs_q;
    a_sum = {dc_q[33], dc_q} - {qs_q[33], qs_q};
    b_sum = {ds_q[33], ds_q} + {qc_q[33], qc_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Lat-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: fold the angle into the first quadrant
      d_q[0]  <= volt_d_i;
      q_q[0]  <= volt_q_i;
      us_q[0] <= sine_arg(p_s);
      uc_q[0] <= sine_arg(p_c);
      ns_q[0] <= p_s[15];
      nc_q[0] <= p_c[15];
      // stage 2: u squared
      d_q[1]   <= d_q[0];
      q_q[1]   <= q_q[0];
      us_q[1]  <= us_q[0];
      uc_q[1]  <= uc_q[0];
      ns_q[1]  <= ns_q[0];
      nc_q[1]  <= nc_q[0];
      u2s_q[0] <= sq_s[30:15];
      u2c_q[0] <= sq_c[30:15];
      // stage 3
      d_q[2]   <= d_q[1];
      q_q[2]   <= q_q[1];
      us_q[2]  <= us_q[1];
      uc_q[2]  <= uc_q[1];
      ns_q[2]  <= ns_q[1];
      nc_q[2]  <= nc_q[1];
      u2s_q[1] <= u2s_q[0];
      u2c_q[1] <= u2c_q[0];
      t1s_q    <= SinB - 16'(m2s[27:15]);
      t1c_q    <= SinB - 16'(m2c[27:15]);
      // stage 4
      d_q[3]  <= d_q[2];
      q_q[3]  <= q_q[2];
      us_q[3] <= us_q[2];
      uc_q[3] <= uc_q[2];
      ns_q[3] <= ns_q[2];
      nc_q[3] <= nc_q[2];
      t2s_q   <= SinA - m3s[30:15];
      t2c_q   <= SinA - m3c[30:15];
      // stage 5: signed sine and cosine
      d_q[4] <= d_q[3];
      q_q[4] <= q_q[3];
      sn_q   <= ns_q[3] ? -$signed({2'b00, m5s[30:15]}) : $signed({2'b00, m5s[30:15]});
      cs_q   <= nc_q[3] ? -$signed({2'b00, m5c[30:15]}) : $signed({2'b00, m5c[30:15]});
      // stage 6: four products
      dc_q <= dc_d;
      qs_q <= qs_d;
      ds_q <= ds_d;
      qc_q <= qc_d;
      // stage 7: floor by 2^7
      ab_q.alpha <= a_sum[34:7];
      ab_q.beta  <= b_sum[34:7];
    end
  end

  assign vld_o = vld_q[Lat-1];
  assign ab_o  = ab_q;

endmodule

>>> src/svm_sector.sv
`timescale 1ns / 1ps
// Sector decision from three sign tests and selection of the two active vectors.
// Depends on svm_pkg.
module svm_sector import svm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  ab_t  ab_i,
  output logic vld_o,
  output xy_t  xy_o
);

  localparam int Lat = 3;

  logic [Lat-1:0] vld_q;
  logic signed [MW-1:0]  m_q;
  logic signed [AbW-1:0] beta_q;
  logic signed [VW-1:0]  v1_q, v2_q, v3_q;
  logic [2:0] sec_q;
  xy_t xy_q;

  logic signed [45:0]   mp;
  logic signed [VW-1:0] v1_d, v2_d, v3_d, bext, mext, xs, ys;
  logic [2:0] n;

  always_comb begin
    mp   = ab_i.alpha * $signed({1'b0, Sqrt3});
    bext = VW'(beta_q);
    mext = VW'(m_q);
    v1_d = bext <<< 1;
    v2_d = mext - bext;
    v3_d = -mext - bext;
    n[0] = !v1_d[VW-1] && (v1_d != '0);
    n[1] = !v2_d[VW-1] && (v2_d != '0);
    n[2] = !v3_d[VW-1] && (v3_d != '0);
  end

  always_comb begin
    case (sec_q)
      Sec1:    begin xs = v2_q;  ys = v1_q;  end
      Sec2:    begin xs = -v2_q; ys = -v3_q; end
      Sec3:    begin xs = v1_q;  ys = v3_q;  end
      Sec4:    begin xs = -v1_q; ys = -v2_q; end
      Sec5:    begin xs = v3_q;  ys = v2_q;  end
      default: begin xs = -v3_q; ys = -v1_q; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Lat-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q    <= mp[45:16];
      beta_q <= ab_i.beta;
      v1_q   <= v1_d;
      v2_q   <= v2_d;
      v3_q   <= v3_d;
      sec_q  <= sector_of_n(n);
      xy_q.sector <= sec_q;
      // clamp at zero
      xy_q.x <= xs[VW-1] ? '0 : XW'(xs);
      xy_q.y <= ys[VW-1] ? '0 : XW'(ys);
    end
  end

  assign vld_o = vld_q[Lat-1];
  assign xy_o  = xy_q;

endmodule

>>> src/svm_vtime.sv
`timescale 1ns / 1ps
// Active vector times: split multiply, bit-per-stage division by the bus voltage,
// then proportional scaling by bit-per-stage division when overmodulated. Uses svm_pkg.
module svm_vtime import svm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  cfg_t cfg_i,
  input  logic vld_i,
  input  xy_t  xy_i,
  output logic vld_o,
  output vt_t  vt_o
);

  localparam int Lat  = 3 + NW + 2 + QW + 1;
  localparam int PW   = XW + 16;
  localparam int PLoW = PW / 2;
  localparam int KW   = PW - PLoW + 17;
  localparam int THiW = NW - NW / 2;
  localparam int TLoW = NW / 2;
  localparam int DivW = NW + 16;

  typedef struct packed {
    logic [14:0]   rx;
    logic [14:0]   ry;
    logic [NW-1:0] wx;
    logic [NW-1:0] wy;
    logic [2:0]    sector;
  } bdiv_t;

  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [SumW-1:0] rx;
    logic [SumW-1:0] ry;
    logic [QW-1:0]   wx;
    logic [QW-1:0]   wy;
    logic [15:0]     tx;
    logic [15:0]     ty;
    logic            over;
    logic [2:0]      sector;
  } sdiv_t;

  logic [Lat-1:0] vld_q;

  logic [PW-1:0] px_q, py_q;
  logic [2:0]    sec1_q, sec2_q, sec4_q;
  logic [KW-1:0] hx_q, lx_q, hy_q, ly_q;
  bdiv_t bd_q [NW+1];
  logic [SumW-1:0] sum_q;
  logic            over_q;
  logic [15:0]     tx4_q, ty4_q;
  logic [THiW+15:0] ahx_q, ahy_q;
  logic [TLoW+15:0] alx_q, aly_q;
  sdiv_t sd_q [QW+1];
  vt_t vt_q;

  logic [KW+PLoW-1:0] nx_full, ny_full;
  logic [NW-1:0] tx_raw, ty_raw;
  logic [SumW-1:0] sum_d;
  logic [DivW-1:0] divx, divy;

  always_comb begin
    nx_full = {hx_q, {PLoW{1'b0}}} + (KW + PLoW)'(lx_q);
    ny_full = {hy_q, {PLoW{1'b0}}} + (KW + PLoW)'(ly_q);
    tx_raw  = bd_q[NW].wx;
    ty_raw  = bd_q[NW].wy;
    sum_d   = {1'b0, tx_raw} + {1'b0, ty_raw};
    divx    = {ahx_q, {TLoW{1'b0}}} + DivW'(alx_q);
    divy    = {ahy_q, {TLoW{1'b0}}} + DivW'(aly_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Lat-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q   <= xy_i.x * cfg_i.period;
      py_q   <= xy_i.y * cfg_i.period;
      sec1_q <= xy_i.sector;
      hx_q   <= px_q[PW-1:PLoW] * Sqrt3;
      lx_q   <= KW'(px_q[PLoW-1:0] * Sqrt3);
      hy_q   <= py_q[PW-1:PLoW] * Sqrt3;
      ly_q   <= KW'(py_q[PLoW-1:0] * Sqrt3);
      sec2_q <= sec1_q;
      // drop the 2^25 scale ahead of the division by the bus voltage
      bd_q[0].rx     <= '0;
      bd_q[0].ry     <= '0;
      bd_q[0].wx     <= nx_full[KW+PLoW-1:25];
      bd_q[0].wy     <= ny_full[KW+PLoW-1:25];
      bd_q[0].sector <= sec2_q;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_bdiv
    logic [15:0] trx, try_;
    logic        gx, gy;
    bdiv_t       nxt;
    always_comb begin
      trx  = {bd_q[k].rx, bd_q[k].wx[NW-1]};
      try_ = {bd_q[k].ry, bd_q[k].wy[NW-1]};
      gx   = trx >= {1'b0, cfg_i.bus};
      gy   = try_ >= {1'b0, cfg_i.bus};
      nxt  = bd_q[k];
      nxt.rx = gx ? 15'(trx - {1'b0, cfg_i.bus}) : trx[14:0];
      nxt.ry = gy ? 15'(try_ - {1'b0, cfg_i.bus}) : try_[14:0];
      nxt.wx = {bd_q[k].wx[NW-2:0], gx};
      nxt.wy = {bd_q[k].wy[NW-2:0], gy};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        bd_q[k+1] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q  <= sum_d;
      over_q <= sum_d > SumW'(cfg_i.period);
      tx4_q  <= tx_raw[15:0];
      ty4_q  <= ty_raw[15:0];
      sec4_q <= bd_q[NW].sector;
      ahx_q  <= tx_raw[NW-1:TLoW] * cfg_i.period;
      alx_q  <= tx_raw[TLoW-1:0] * cfg_i.period;
      ahy_q  <= ty_raw[NW-1:TLoW] * cfg_i.period;
      aly_q  <= ty_raw[TLoW-1:0] * cfg_i.period;
      // quotient never exceeds the period, so start with the upper part as remainder
      sd_q[0].sum    <= sum_q;
      sd_q[0].rx     <= SumW'(divx[DivW-1:QW]);
      sd_q[0].ry     <= SumW'(divy[DivW-1:QW]);
      sd_q[0].wx     <= divx[QW-1:0];
      sd_q[0].wy     <= divy[QW-1:0];
      sd_q[0].tx     <= tx4_q;
      sd_q[0].ty     <= ty4_q;
      sd_q[0].over   <= over_q;
      sd_q[0].sector <= sec4_q;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_sdiv
    logic [SumW:0] trx, try_;
    logic          gx, gy;
    sdiv_t         nxt;
    always_comb begin
      trx  = {sd_q[k].rx, sd_q[k].wx[QW-1]};
      try_ = {sd_q[k].ry, sd_q[k].wy[QW-1]};
      gx   = trx >= {1'b0, sd_q[k].sum};
      gy   = try_ >= {1'b0, sd_q[k].sum};
      nxt  = sd_q[k];
      nxt.rx = gx ? SumW'(trx - {1'b0, sd_q[k].sum}) : trx[SumW-1:0];
      nxt.ry = gy ? SumW'(try_ - {1'b0, sd_q[k].sum}) : try_[SumW-1:0];
      nxt.wx = {sd_q[k].wx[QW-2:0], gx};
      nxt.wy = {sd_q[k].wy[QW-2:0], gy};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sd_q[k+1] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vt_q.sector <= sd_q[QW].sector;
      vt_q.over   <= sd_q[QW].over;
      vt_q.tx     <= sd_q[QW].over ? sd_q[QW].wx : sd_q[QW].tx;
      vt_q.ty     <= sd_q[QW].over ? sd_q[QW].wy : sd_q[QW].ty;
    end
  end

  assign vld_o = vld_q[Lat-1];
  assign vt_o  = vt_q;

endmodule

>>> src/svm_compare.sv
`timescale 1ns / 1ps
// Seven-segment compare values per phase and the ADC sample point.
// Depends on svm_pkg.
module svm_compare import svm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  cfg_t cfg_i,
  input  logic vld_i,
  input  vt_t  vt_i,
  output logic vld_o,
  output res_t res_o
);

  localparam int Lat = 3;

  logic [Lat-1:0] vld_q;
  logic [15:0] ta_q, tb_q, tc_q;
  logic [2:0]  sec1_q, sec2_q;
  logic        over1_q, over2_q;
  logic [15:0] ca_q, cb_q, cc_q, limm1_q, lbef_q, laft_q;
  logic        c1_q, c2_q;
  res_t res_q;

  logic [17:0] ta18, tb18, tc18;
  logic [15:0] ca_d, cb_d, cc_d, gap, delta, fold, trig;

  always_comb begin
    ta18 = {2'b00, cfg_i.period} - {2'b00, vt_i.tx} - {2'b00, vt_i.ty};
    tb18 = {2'b00, cfg_i.period} + {2'b00, vt_i.tx} - {2'b00, vt_i.ty};
    tc18 = {2'b00, cfg_i.period} + {2'b00, vt_i.tx} + {2'b00, vt_i.ty};
    gap   = cfg_i.limit - ta_q;
    delta = ta_q - tb_q;
    case (sec1_q)
      Sec1:    begin ca_d = ta_q; cb_d = tb_q; cc_d = tc_q; end
      Sec2:    begin ca_d = tb_q; cb_d = ta_q; cc_d = tc_q; end
      Sec3:    begin ca_d = tc_q; cb_d = ta_q; cc_d = tb_q; end
      Sec4:    begin ca_d = tc_q; cb_d = tb_q; cc_d = ta_q; end
      Sec5:    begin ca_d = tb_q; cb_d = tc_q; cc_d = ta_q; end
      default: begin ca_d = ta_q; cb_d = tc_q; cc_d = tb_q; end
    endcase
    // reflect a late sample point about the compare limit
    fold = (laft_q >= cfg_i.limit) ? 16'(cfg_i.limit + cfg_i.limit - laft_q - 16'd1)
                                   : laft_q;
    trig = c1_q ? limm1_q : (c2_q ? lbef_q : fold);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Lat-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ta_q    <= ta18[17:2];
      tb_q    <= tb18[17:2];
      tc_q    <= tc18[17:2];
      sec1_q  <= vt_i.sector;
      over1_q <= vt_i.over;
      ca_q    <= ca_d;
      cb_q    <= cb_d;
      cc_q    <= cc_d;
      sec2_q  <= sec1_q;
      over2_q <= over1_q;
      c1_q    <= gap > cfg_i.after;
      c2_q    <= {1'b0, delta} > {gap, 1'b0};
      limm1_q <= cfg_i.limit - 16'd1;
      lbef_q  <= ta_q - cfg_i.prior;
      laft_q  <= ta_q + cfg_i.after;
      if (sec2_q == SecNone) begin
        res_q <= '0;
      end else begin
        res_q.sector <= sec2_q;
        res_q.ca     <= ca_q;
        res_q.cb     <= cb_q;
        res_q.cc     <= cc_q;
        res_q.trig   <= trig;
        res_q.over   <= over2_q;
      end
    end
  end

  assign vld_o = vld_q[Lat-1];
  assign res_o = res_q;

endmodule

>>> src/svpwm_modulator.sv
`timescale 1ns / 1ps
// Space vector PWM modulator top level: configuration registers, pipeline, output skid.
// Depends on svm_pkg, svm_park, svm_sector, svm_vtime and svm_compare.
//
// One d/q voltage command with an electrical angle enters on the s_axis channel and
// yields one result on m_axis: sector, three phase compare values, the ADC sample
// point and an overmodulation flag. Registers are written on the cfg channel
// (index 0 period, 1 compare limit, 2 bus voltage, 3 window after, 4 window before;
// other indexes are ignored); cfg_ready_o is always high and writes belong only
// to idle periods.
// Requests pass through sine and Park, the sector, the vector times (36 stages
// divide by the bus voltage one quotient bit each, 16 more scale the times) and
// compares and sample point, then the output register. One request is taken
// every cycle while s_axis_tready is high.
// Reset restores the register defaults and empties the pipeline. When m_axis
// stalls, one result waits in the output register and the next in a skid register;
// once the skid is full the pipeline holds and s_axis_tready drops until it drains.
module svpwm_modulator import svm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [47:0]        s_axis_tdata,   // volt_d, volt_q, rotor_angle
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // sector_number, compare_phase_a, compare_phase_b, compare_phase_c,
  // sample_trigger, overmodulated, zero fill
  output logic [71:0]        m_axis_tdata,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  logic [15:0] period_q, limit_q, after_q, before_q;
  logic [14:0] bus_q;
  cfg_t cfg;

  logic en;
  logic park_vld, sec_vld, vt_vld, res_vld, take;
  ab_t  ab;
  xy_t  xy;
  vt_t  vt;
  res_t res;

  logic out_vld_q, out_vld_d, sk_vld_q, sk_vld_d;
  res_t out_q, out_d, sk_q, sk_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= 16'd5250;
      limit_q  <= 16'd5250;
      bus_q    <= 15'd5888;
      after_q  <= '0;
      before_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegPeriod: period_q <= cfg_data_i;
        RegLimit:  limit_q  <= cfg_data_i;
        RegBus:    bus_q    <= cfg_data_i[14:0];
        RegAfter:  after_q  <= cfg_data_i;
        RegBefore: before_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  always_comb begin
    cfg.period = period_q;
    cfg.limit  = limit_q;
    cfg.bus    = (bus_q == '0) ? 15'd1 : bus_q;
    cfg.after  = after_q;
    cfg.prior  = before_q;
  end

  assign en            = !sk_vld_q;
  assign s_axis_tready = en;

  svm_park u_park (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (s_axis_tvalid),
    .volt_d_i (s_axis_tdata[15:0]),
    .volt_q_i (s_axis_tdata[31:16]),
    .angle_i  (s_axis_tdata[47:32]),
    .vld_o    (park_vld),
    .ab_o     (ab)
  );

  svm_sector u_sector (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (park_vld),
    .ab_i   (ab),
    .vld_o  (sec_vld),
    .xy_o   (xy)
  );

  svm_vtime u_vtime (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .cfg_i  (cfg),
    .vld_i  (sec_vld),
    .xy_i   (xy),
    .vld_o  (vt_vld),
    .vt_o   (vt)
  );

  svm_compare u_compare (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .cfg_i  (cfg),
    .vld_i  (vt_vld),
    .vt_i   (vt),
    .vld_o  (res_vld),
    .res_o  (res)
  );

  assign take = res_vld && en;

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    sk_vld_d  = sk_vld_q;
    sk_d      = sk_q;
    if (!out_vld_q || m_axis_tready) begin
      if (sk_vld_q) begin
        out_vld_d = 1'b1;
        out_d     = sk_q;
        sk_vld_d  = 1'b0;
      end else begin
        out_vld_d = take;
        out_d     = res;
      end
    end else if (take) begin
      // hold the new result aside while the receiver stalls
      sk_vld_d = 1'b1;
      sk_d     = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      sk_vld_q  <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      sk_vld_q  <= sk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sk_q  <= sk_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, out_q.over, out_q.trig, out_q.cc, out_q.cb, out_q.ca,
                          out_q.sector};

endmodule
